@@ rtl/pi_speed_controller_top_macros.svh @@
// ----------------------------------------------------------------------------
// pi_speed_controller_top_macros.svh
// Assertion shorthands for the PI speed controller, clocked on clk,
// held off during rst.
// ----------------------------------------------------------------------------
`ifndef PI_SPEED_CONTROLLER_TOP_MACROS_SVH
`define PI_SPEED_CONTROLLER_TOP_MACROS_SVH

// cons must hold in the same cycle as ante
`define PISC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define PISC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pisc_pkg.sv @@
// ----------------------------------------------------------------------------
// pisc_pkg
// Widths, reset values and register codes of the PI speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pisc_pkg;

  localparam int SPEED_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DRIVE_W    = 27;

  localparam int SP_FRAC    = 16;               // Q0.16 step, Q17.16 integrator
  localparam int ERR_W      = SPEED_W + 2;      // -32767 .. 98303
  localparam int INTEG_W    = 34;
  localparam int ISUM_W     = INTEG_W + 1;
  localparam int MCAND_W    = INTEG_W;          // widest multiplicand
  localparam int ACC_W      = MCAND_W + 1;
  localparam int MPL_W      = GAIN_W;           // multiplier bits, one per step
  localparam int CNT_W      = $clog2(MPL_W);
  localparam int PROD_W     = ACC_W + MPL_W;
  localparam int SUM_W      = PROD_W;

  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int DRIVE_MAX = 2 ** (DRIVE_W - 1) - 1;
  localparam int DRIVE_MIN = -(2 ** (DRIVE_W - 1));

  localparam logic [GAIN_W-1:0] KP_GAIN_RST        = 16'd717;
  localparam logic [GAIN_W-1:0] KI_GAIN_RST        = 16'd461;
  localparam logic [GAIN_W-1:0] SAMPLE_PERIOD_RST  = 16'd328;
  localparam logic [GAIN_W-1:0] INTEGRAL_LIMIT_RST = 16'd1000;
  localparam logic [GAIN_W-1:0] OUTPUT_LIMIT_RST   = 16'd19000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN        = 3'd0,
    REG_KI_GAIN        = 3'd1,
    REG_SAMPLE_PERIOD  = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/pisc_if.sv @@
// ----------------------------------------------------------------------------
// pisc_if
// Valid/ready channels of the PI speed controller: speed sample in,
// drive out, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface pisc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [pisc_pkg::SPEED_W-1:0]  target_speed;
  logic signed [pisc_pkg::SPEED_W-1:0]  measured_speed;

  modport source (output valid, target_speed, measured_speed, input ready);
  modport sink   (input valid, target_speed, measured_speed, output ready);
endinterface

interface pisc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pisc_pkg::DRIVE_W-1:0]  drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface pisc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic        [pisc_pkg::CFG_IDX_W-1:0]  index;
  logic        [pisc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/pi_speed_controller_top.sv @@
// ----------------------------------------------------------------------------
// pi_speed_controller_top
// PI wheel speed controller with integrator clamp and optional drive clamp.
//
// req carries one word per control tick (target and measured speed); rsp
// returns one drive word for each. cfg writes the five gain/limit registers
// and is always ready; write it only while no tick is in flight.
// Each tick runs three 16-step shift-add products (err*sample_period,
// err*kp, integrator*ki) one after the other through a single radix-2
// serial multiplier, and no new request is taken until its drive is
// loaded into the output register.
// The drive sits in an output register, so a new request is taken while
// the previous drive waits; if rsp stalls, the next drive holds in its last
// step until the register frees up.
// Reset clears the integrator, loads the default gains and limits and
// empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pi_speed_controller_top #(
  parameter int GAIN_FRAC_BITS = pisc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  pisc_in_if.sink      req,
  pisc_out_if.source   rsp,
  pisc_cfg_if.sink     cfg
);

  `include "pi_speed_controller_top_macros.svh"

  localparam int SHIFT = GAIN_FRAC_BITS + pisc_pkg::SP_FRAC;
  localparam int Q_W   = pisc_pkg::SUM_W - SHIFT;
  localparam int CMP_W = (Q_W > pisc_pkg::DRIVE_W) ? Q_W : pisc_pkg::DRIVE_W + 1;
  localparam logic [pisc_pkg::CNT_W-1:0] CNT_LAST = pisc_pkg::CNT_W'(pisc_pkg::MPL_W - 1);
  localparam logic signed [CMP_W-1:0] DMAX_X = CMP_W'(pisc_pkg::DRIVE_MAX);
  localparam logic signed [CMP_W-1:0] DMIN_X = CMP_W'(pisc_pkg::DRIVE_MIN);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_IADD, ST_ICLAMP, ST_MUL2, ST_KEEP, ST_MUL3,
    ST_SUM, ST_ROUND, ST_OUT
  } state_t;

  // registers
  logic [pisc_pkg::GAIN_W-1:0] kp_gain, ki_gain, sample_period;
  logic [pisc_pkg::GAIN_W-1:0] integral_limit, output_limit;

  state_t                                  state;
  logic signed [pisc_pkg::ERR_W-1:0]       err;
  logic signed [pisc_pkg::INTEG_W-1:0]     integrator;
  logic signed [pisc_pkg::ISUM_W-1:0]      isum;
  logic signed [pisc_pkg::MCAND_W-1:0]     mcand;
  logic signed [pisc_pkg::ACC_W-1:0]       acc;
  logic        [pisc_pkg::MPL_W-1:0]       mq;
  logic        [pisc_pkg::CNT_W-1:0]       cnt;
  logic signed [pisc_pkg::SUM_W-1:0]       sum;
  logic signed [Q_W-1:0]                   q;
  logic                                    out_valid;
  logic signed [pisc_pkg::DRIVE_W-1:0]     out_drive;

  // combinational
  logic signed [pisc_pkg::ERR_W-1:0]       err_in;
  logic signed [pisc_pkg::ACC_W-1:0]       addend, acc_sum, acc_step;
  logic        [pisc_pkg::MPL_W-1:0]       mq_step;
  logic signed [pisc_pkg::PROD_W-1:0]      prod;
  logic signed [pisc_pkg::INTEG_W-1:0]     prod_lo;
  logic signed [pisc_pkg::ISUM_W-1:0]      ilim, neg_ilim, integ_x;
  logic signed [pisc_pkg::SUM_W-1:0]       rsum;
  logic signed [CMP_W-1:0]                 qx, olim_x, neg_olim_x, drive_next;
  logic signed [pisc_pkg::DRIVE_W-1:0]     olim_d;
  logic                                    acc_in;

  assign acc_in    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.drive = out_drive;
  assign cfg.ready = 1'b1;

  assign err_in = {{(pisc_pkg::ERR_W - pisc_pkg::SPEED_W){1'b0}}, req.target_speed}
                - pisc_pkg::ERR_W'(req.measured_speed);

  // radix-2 shift-add step: signed multiplicand, unsigned multiplier LSB first
  assign addend   = mq[0] ? pisc_pkg::ACC_W'(mcand) : '0;
  assign acc_sum  = acc + addend;
  assign acc_step = acc_sum >>> 1;
  assign mq_step  = {acc_sum[0], mq[pisc_pkg::MPL_W-1:1]};
  assign prod     = {acc, mq};
  assign prod_lo  = prod[pisc_pkg::INTEG_W-1:0];

  assign ilim     = {{(pisc_pkg::ISUM_W - pisc_pkg::GAIN_W - pisc_pkg::SP_FRAC){1'b0}},
                     integral_limit, {pisc_pkg::SP_FRAC{1'b0}}};
  assign neg_ilim = -ilim;
  assign integ_x  = pisc_pkg::ISUM_W'(integrator);

  // truncate toward zero: bias negative sums by 2^SHIFT - 1 before the shift
  assign rsum = sum + {{(pisc_pkg::SUM_W - SHIFT){1'b0}}, {SHIFT{sum[pisc_pkg::SUM_W-1]}}};

  assign qx         = CMP_W'(q);
  assign olim_x     = CMP_W'({1'b0, output_limit});
  assign neg_olim_x = -olim_x;
  assign olim_d     = pisc_pkg::DRIVE_W'(output_limit);

  always_comb begin
    if (output_limit != '0 && qx > olim_x) begin
      drive_next = olim_x;
    end else if (output_limit != '0 && qx < neg_olim_x) begin
      drive_next = neg_olim_x;
    end else if (qx > DMAX_X) begin
      drive_next = DMAX_X;
    end else if (qx < DMIN_X) begin
      drive_next = DMIN_X;
    end else begin
      drive_next = qx;
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain        <= pisc_pkg::KP_GAIN_RST;
      ki_gain        <= pisc_pkg::KI_GAIN_RST;
      sample_period  <= pisc_pkg::SAMPLE_PERIOD_RST;
      integral_limit <= pisc_pkg::INTEGRAL_LIMIT_RST;
      output_limit   <= pisc_pkg::OUTPUT_LIMIT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        pisc_pkg::REG_KP_GAIN:        kp_gain        <= cfg.data;
        pisc_pkg::REG_KI_GAIN:        ki_gain        <= cfg.data;
        pisc_pkg::REG_SAMPLE_PERIOD:  sample_period  <= cfg.data;
        pisc_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg.data;
        pisc_pkg::REG_OUTPUT_LIMIT:   output_limit   <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      integrator <= '0;
      cnt        <= '0;
    end else begin
      // in ST_OUT the load below owns out_valid
      if (out_valid && rsp.ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc_in) begin
            err   <= err_in;
            mcand <= pisc_pkg::MCAND_W'(err_in);
            acc   <= '0;
            mq    <= sample_period;
            cnt   <= '0;
            state <= ST_MUL1;
          end
        end
        ST_MUL1, ST_MUL2, ST_MUL3: begin
          acc <= acc_step;
          mq  <= mq_step;
          cnt <= cnt + pisc_pkg::CNT_W'(1);
          if (cnt == CNT_LAST) begin
            unique case (state)
              ST_MUL1: state <= ST_IADD;
              ST_MUL2: state <= ST_KEEP;
              default: state <= ST_SUM;
            endcase
          end
        end
        ST_IADD: begin
          isum  <= integ_x + pisc_pkg::ISUM_W'(prod_lo);
          state <= ST_ICLAMP;
        end
        ST_ICLAMP: begin
          if (isum > ilim) begin
            integrator <= ilim[pisc_pkg::INTEG_W-1:0];
          end else if (isum < neg_ilim) begin
            integrator <= neg_ilim[pisc_pkg::INTEG_W-1:0];
          end else begin
            integrator <= isum[pisc_pkg::INTEG_W-1:0];
          end
          mcand <= pisc_pkg::MCAND_W'(err);
          acc   <= '0;
          mq    <= kp_gain;
          cnt   <= '0;
          state <= ST_MUL2;
        end
        ST_KEEP: begin
          // err*kp moved up to the integrator's Q.16 scale
          sum   <= {prod[pisc_pkg::SUM_W-pisc_pkg::SP_FRAC-1:0], {pisc_pkg::SP_FRAC{1'b0}}};
          mcand <= integrator;
          acc   <= '0;
          mq    <= ki_gain;
          cnt   <= '0;
          state <= ST_MUL3;
        end
        ST_SUM: begin
          sum   <= sum + prod;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          q     <= rsum[pisc_pkg::SUM_W-1:SHIFT];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_drive <= drive_next[pisc_pkg::DRIVE_W-1:0];
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `PISC_ASSERT_NEXT(a_start, acc_in, (state == ST_MUL1 && cnt == '0), "multiply did not start")
  `PISC_ASSERT_NOW(a_integ_clamp, (state == ST_MUL2), (integ_x <= ilim && integ_x >= neg_ilim), "integrator outside its clamp")
  `PISC_ASSERT_NOW(a_drive_clamp, (out_valid && output_limit != '0), (out_drive <= olim_d && out_drive >= -olim_d), "drive outside its clamp")
  `PISC_ASSERT_NEXT(a_out_load, (state == ST_OUT && !out_valid), (out_valid && state == ST_IDLE), "free output register not loaded")

endmodule

`default_nettype wire

@@ sim/pi_speed_controller_top_tb.sv @@
// ----------------------------------------------------------------------------
// pi_speed_controller_top_tb
// Self-checking bench for the PI wheel speed controller. A short table of
// speed words and register writes hits the limits and the clamp cases, then
// random phases change the gains and limits while the block is idle and send
// speed words. Drive words come out of an in-bench model, or from the table
// where a row fixes them, and are checked in order. Sender bursts, receiver
// stall patterns and long back-pressure are all in play.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pi_speed_controller_top_tb;
  import pisc_pkg::*;

  localparam int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF;
  localparam int ITEM_TOTAL     = 1950;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 600;
  localparam int HOLD_AT_A      = 400;
  localparam int HOLD_AT_B      = 1300;
  localparam int MAX_REPORTS    = 40;
  localparam int DIRECTED_ROWS  = 32;

  // indexes past the register file, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef enum int {
    MIX_TYPICAL, MIX_RANDOM, MIX_ALL_MAX, MIX_ALL_ZERO, MIX_NO_INTEG, MIX_NO_CLAMP
  } cfg_mix_t;

  typedef struct packed {
    logic                        is_cfg;
    logic [CFG_IDX_W-1:0]        idx;
    logic [CFG_DATA_W-1:0]       data;
    logic [SPEED_W-1:0]          tgt;
    logic signed [SPEED_W-1:0]   meas;
    logic                        fixed;
    logic signed [DRIVE_W-1:0]   drive;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  always #4 clk = ~clk;

  pisc_in_if  req_ch ();
  pisc_out_if rsp_ch ();
  pisc_cfg_if cfg_ch ();

  pi_speed_controller_top #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // model state, mirrors the block's registers
  logic [GAIN_W-1:0] kp_q   = KP_GAIN_RST;
  logic [GAIN_W-1:0] ki_q   = KI_GAIN_RST;
  logic [GAIN_W-1:0] step_q = SAMPLE_PERIOD_RST;
  logic [GAIN_W-1:0] ilim_q = INTEGRAL_LIMIT_RST;
  logic [GAIN_W-1:0] olim_q = OUTPUT_LIMIT_RST;
  longint            integ_q = 0;

  logic signed [DRIVE_W-1:0] drive_q [$];
  int                        words_owed = 0;
  int                        items_accepted = 0;
  int                        mismatches = 0;

  // fixed expectation travels with the speed word
  logic                      fixed_d;
  logic signed [DRIVE_W-1:0] fixed_drive_d;

  int burst_left = 0;
  int items_issued = 0;

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_KP_GAIN:        kp_q = data;
      REG_KI_GAIN:        ki_q = data;
      REG_SAMPLE_PERIOD:  step_q = data;
      REG_INTEGRAL_LIMIT: ilim_q = data;
      REG_OUTPUT_LIMIT:   olim_q = data;
      default: ;
    endcase
  endfunction

  // advances the integrator and returns the drive for one tick
  function automatic logic signed [DRIVE_W-1:0] next_drive(
      input logic [SPEED_W-1:0] tgt, input logic signed [SPEED_W-1:0] meas);
    longint err, lim, olim, sum, mag, d;
    bit     neg;
    err = longint'(tgt) - longint'(meas);
    lim = longint'(ilim_q) * 65536;
    integ_q = integ_q + err * longint'(step_q);
    if (integ_q > lim) integ_q = lim;
    else if (integ_q < -lim) integ_q = -lim;
    sum = err * longint'(kp_q) * 65536 + integ_q * longint'(ki_q);
    neg = sum < 0;
    mag = neg ? -sum : sum;
    mag = mag >> (GAIN_FRAC_BITS + SP_FRAC);
    d = neg ? -mag : mag;
    olim = longint'(olim_q);
    if (olim != 0) begin
      if (d > olim) d = olim;
      else if (d < -olim) d = -olim;
    end
    if (d > longint'(DRIVE_MAX)) d = longint'(DRIVE_MAX);
    else if (d < longint'(DRIVE_MIN)) d = longint'(DRIVE_MIN);
    return d[DRIVE_W-1:0];
  endfunction

  function automatic step_row_t item_row(input logic [SPEED_W-1:0] tgt,
                                         input logic signed [SPEED_W-1:0] meas);
    step_row_t r;
    r = '0;
    r.tgt = tgt;
    r.meas = meas;
    return r;
  endfunction

  function automatic step_row_t fixed_row(input logic [SPEED_W-1:0] tgt,
                                          input logic signed [SPEED_W-1:0] meas,
                                          input int drv);
    step_row_t r;
    r = item_row(tgt, meas);
    r.fixed = 1'b1;
    r.drive = DRIVE_W'(drv);
    return r;
  endfunction

  function automatic step_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    step_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  // one speed word; a burst that has run out first takes a gap
  task automatic send_speed(input logic [SPEED_W-1:0] tgt,
                            input logic signed [SPEED_W-1:0] meas,
                            input logic fixed, input logic signed [DRIVE_W-1:0] drv);
    int gap;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      gap = $urandom_range(1, 80);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
    req_ch.valid <= 1'b1;
    req_ch.target_speed <= tgt;
    req_ch.measured_speed <= meas;
    fixed_d <= fixed;
    fixed_drive_d <= drv;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    items_issued++;
  endtask

  // stop offering and wait until every drive word is back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    logic signed [DRIVE_W-1:0] want;
    logic                      took;
    took = 1'b0;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
      if (req_ch.valid && req_ch.ready) begin
        want = next_drive(req_ch.target_speed, req_ch.measured_speed);
        if (fixed_d) want = fixed_drive_d;
        drive_q.push_back(want);
        took = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: drive word with none owed: expected none, actual %0d",
                     $time, rsp_ch.drive);
        end else begin
          want = drive_q.pop_front();
          if (rsp_ch.drive !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: drive mismatch: expected %0d, actual %0d",
                       $time, want, rsp_ch.drive);
          end
        end
      end
      words_owed <= drive_q.size();
      if (took) items_accepted <= items_accepted + 1;
    end
  end

  // receiver: stall patterns, plus two long hold-offs while words are offered
  initial begin : receiver
    int          hold_left;
    int          pos;
    logic [31:0] pat;
    logic [1:0]  held;
    hold_left = 0;
    pos = 0;
    pat = '1;
    held = '0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (!held[0] && items_accepted >= HOLD_AT_A && req_ch.valid) begin
        held[0] = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (!held[1] && items_accepted >= HOLD_AT_B && req_ch.valid) begin
        held[1] = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (pos == 0) begin
          case ($urandom_range(0, 3))
            0:       pat = '1;
            1:       pat = $urandom;
            default: pat = $urandom | $urandom;
          endcase
        end
        rsp_ch.ready <= pat[pos];
        pos = (pos + 1) % 32;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pi_speed_controller_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    step_row_t                directed_steps [DIRECTED_ROWS];
    logic                     cfg_open;
    cfg_mix_t                 mix;
    logic [GAIN_W-1:0]        kp_v, ki_v, sp_v, il_v, ol_v;
    logic [SPEED_W-1:0]       tgt;
    logic signed [SPEED_W-1:0] meas;
    int                       m;
    int                       phase_len;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.target_speed <= '0;
    req_ch.measured_speed <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_KP_GAIN;
    cfg_ch.data <= '0;
    fixed_d <= 1'b0;
    fixed_drive_d <= '0;

    directed_steps = '{
      fixed_row('0, '0, 0),                       // after reset
      fixed_row('1, 16'sh8000, 19000),            // largest error, drive clamp
      fixed_row('0, 16'sh7FFF, -19000),           // most negative error
      item_row('0, 16'sh8000),
      item_row('1, 16'sh7FFF),
      cfg_row(IDX_SPARE_LO, '0),                  // dropped writes
      cfg_row(IDX_SPARE_HI, '1),
      item_row(16'd1000, 16'sd1000),              // zero error, integral term only
      cfg_row(REG_OUTPUT_LIMIT, '0),              // drive clamp off
      item_row('1, 16'sh8000),
      item_row('0, 16'sh7FFF),
      cfg_row(REG_KP_GAIN, '1),
      cfg_row(REG_KI_GAIN, '1),
      cfg_row(REG_SAMPLE_PERIOD, '1),
      cfg_row(REG_INTEGRAL_LIMIT, '1),
      item_row('1, 16'sh8000),                    // integrator hits +limit
      item_row('1, 16'sh8000),
      item_row('0, 16'sh7FFF),                    // falls back toward zero
      item_row('0, 16'sh7FFF),
      cfg_row(REG_OUTPUT_LIMIT, '1),
      item_row('1, 16'sh8000),
      cfg_row(REG_KP_GAIN, '0),
      cfg_row(REG_INTEGRAL_LIMIT, '0),            // integrator pinned at zero
      fixed_row('1, 16'sh8000, 0),
      fixed_row('0, 16'sh7FFF, 0),
      cfg_row(REG_KP_GAIN, KP_GAIN_RST),
      cfg_row(REG_KI_GAIN, KI_GAIN_RST),
      cfg_row(REG_SAMPLE_PERIOD, '0),             // integrator frozen
      cfg_row(REG_INTEGRAL_LIMIT, INTEGRAL_LIMIT_RST),
      cfg_row(REG_OUTPUT_LIMIT, OUTPUT_LIMIT_RST),
      item_row(16'd500, 16'sd400),
      item_row(16'd400, 16'sd500)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    cfg_open = 1'b0;
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
        end
        write_reg(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        if (cfg_open) begin
          cfg_ch.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_speed(directed_steps[i].tgt, directed_steps[i].meas,
                   directed_steps[i].fixed, directed_steps[i].drive);
      end
    end

    while (items_issued < ITEM_TOTAL) begin
      wait_idle();
      mix = cfg_mix_t'($urandom_range(0, 5));
      kp_v = 16'($urandom_range(0, 2047));
      ki_v = 16'($urandom_range(0, 2047));
      sp_v = 16'($urandom_range(0, 4095));
      il_v = 16'($urandom_range(0, 5000));
      ol_v = ($urandom_range(0, 3) == 0) ? '0 : 16'($urandom_range(1, 30000));
      case (mix)
        MIX_RANDOM, MIX_NO_CLAMP: begin
          kp_v = 16'($urandom);
          ki_v = 16'($urandom);
          sp_v = 16'($urandom);
          il_v = 16'($urandom);
          ol_v = (mix == MIX_NO_CLAMP) ? '0 : 16'($urandom);
        end
        MIX_ALL_MAX: begin
          kp_v = '1; ki_v = '1; sp_v = '1; il_v = '1; ol_v = '1;
        end
        MIX_ALL_ZERO: begin
          kp_v = '0; ki_v = '0; sp_v = '0; il_v = '0; ol_v = '0;
        end
        MIX_NO_INTEG: il_v = '0;
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), 16'($urandom));
      write_reg(REG_KP_GAIN, kp_v);
      write_reg(REG_KI_GAIN, ki_v);
      write_reg(REG_SAMPLE_PERIOD, sp_v);
      write_reg(REG_INTEGRAL_LIMIT, il_v);
      write_reg(REG_OUTPUT_LIMIT, ol_v);
      cfg_ch.valid <= 1'b0;

      phase_len = $urandom_range(20, 90);
      for (int n = 0; n < phase_len && items_issued < ITEM_TOTAL; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // tracking: measured speed close to target
            tgt = 16'($urandom_range(0, 20000));
            m = int'(tgt) + int'($urandom_range(0, 1000)) - 500;
            meas = m[SPEED_W-1:0];
          end
          6, 7: begin
            tgt = 16'($urandom);
            meas = 16'($urandom);
          end
          8: begin
            tgt = ($urandom_range(0, 1) == 0) ? '1 : '0;
            meas = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
          end
          default: begin
            // wheel running backwards
            tgt = 16'($urandom_range(0, 1000));
            m = -int'($urandom_range(0, 32768));
            meas = m[SPEED_W-1:0];
          end
        endcase
        send_speed(tgt, meas, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("pi_speed_controller_top_tb: clean");
    end else begin
      $display("pi_speed_controller_top_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pisc_pkg.sv
rtl/pisc_if.sv
rtl/pi_speed_controller_top.sv
sim/pi_speed_controller_top_tb.sv
